/* rtl/core/base64_stream_decoder_defines.svh */
// assertion macros used by the base64 stream decoder top level
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// same-cycle implication checked on every clock edge outside reset
`define B64SD_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 decoder assertion failed");

// next-cycle implication checked on every clock edge outside reset
`define B64SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 decoder assertion failed");

`endif

/* rtl/core/b64sd_pkg.sv */
// types and constants shared by the base64 stream decoder modules
`timescale 1ns / 1ps

package b64sd_pkg;

  localparam int unsigned QDepthDefault = 4;

  localparam int unsigned AccW  = 18;
  localparam int unsigned SextW = 6;

  typedef enum logic [2:0] {
    PH_G0   = 3'd0,
    PH_G1   = 3'd1,
    PH_G2   = 3'd2,
    PH_G3   = 3'd3,
    PH_PAD1 = 3'd4,
    PH_DONE = 3'd5,
    PH_ERR  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_SKIP
  } sym_e;

  // one decoded unit of work: up to three result beats
  typedef struct packed {
    logic [2:0][7:0] data;   // data[0] goes out first
    logic [1:0]      cnt;    // number of beats, 1 to 3
    logic            bval;
    logic            err;
    logic            done;
  } b64sd_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64sd_qstat_t;

endpackage

/* rtl/core/b64sd_front.sv */
// front end: accepts characters, decodes sextets and builds result jobs
`timescale 1ns / 1ps

module b64sd_front
  import b64sd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_tvalid_i,
  input  logic         s_tuser_i,
  input  logic [7:0]   s_tdata_i,
  output logic         s_tready_o,
  input  b64sd_qstat_t q_stat_i,
  output logic         push_o,
  output b64sd_job_t   job_o
);

  logic            alt_sym_q;
  phase_e          phase_q, phase_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            fire;
  sym_e            sym_kind;
  logic [SextW-1:0] sext;
  logic            err_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_sym_q <= 1'b0;
    end else if (cfg_we_i) begin
      alt_sym_q <= cfg_wdata_i;
    end
  end

  assign s_tready_o = !q_stat_i.full;
  assign fire       = s_tvalid_i && s_tready_o;

  // alphabet lookup
  always_comb begin
    logic [7:0] t;
    t        = 8'd0;
    sym_kind = SYM_SKIP;
    sext     = '0;
    if (s_tdata_i inside {[8'h41:8'h5A]}) begin
      t        = s_tdata_i - 8'h41;
      sym_kind = SYM_DATA;
    end else if (s_tdata_i inside {[8'h61:8'h7A]}) begin
      t        = s_tdata_i - 8'h61 + 8'd26;
      sym_kind = SYM_DATA;
    end else if (s_tdata_i inside {[8'h30:8'h39]}) begin
      t        = s_tdata_i - 8'h30 + 8'd52;
      sym_kind = SYM_DATA;
    end else if (s_tdata_i == 8'h3D) begin
      sym_kind = SYM_PAD;
    end else if (alt_sym_q && s_tdata_i == 8'h2D) begin
      t        = 8'd62;
      sym_kind = SYM_DATA;
    end else if (alt_sym_q && s_tdata_i == 8'h5F) begin
      t        = 8'd63;
      sym_kind = SYM_DATA;
    end else if (!alt_sym_q && s_tdata_i == 8'h2B) begin
      t        = 8'd62;
      sym_kind = SYM_DATA;
    end else if (!alt_sym_q && s_tdata_i == 8'h2F) begin
      t        = 8'd63;
      sym_kind = SYM_DATA;
    end
    sext = t[SextW-1:0];
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    push_o  = 1'b0;
    job_o   = '0;
    err_go  = 1'b0;
    if (fire) begin
      if (s_tuser_i) begin
        // finish: flush partial group or flag an illegal end
        push_o     = 1'b1;
        job_o.cnt  = 2'd1;
        job_o.done = 1'b1;
        case (phase_q)
          PH_G0, PH_DONE: begin
          end
          PH_G2: begin
            job_o.bval    = 1'b1;
            job_o.data[0] = acc_q[11:4];
          end
          PH_G3: begin
            job_o.bval    = 1'b1;
            job_o.cnt     = 2'd2;
            job_o.data[0] = acc_q[17:10];
            job_o.data[1] = acc_q[9:2];
          end
          default: begin
            job_o.err = 1'b1;
          end
        endcase
        phase_d = PH_G0;
        acc_d   = '0;
      end else begin
        case (phase_q)
          PH_G0: begin
            if (sym_kind == SYM_PAD) begin
              err_go = 1'b1;
            end else if (sym_kind == SYM_DATA) begin
              acc_d   = {12'd0, sext};
              phase_d = PH_G1;
            end
          end
          PH_G1: begin
            if (sym_kind == SYM_PAD) begin
              err_go = 1'b1;
            end else if (sym_kind == SYM_DATA) begin
              acc_d   = {acc_q[11:0], sext};
              phase_d = PH_G2;
            end
          end
          PH_G2: begin
            if (sym_kind == SYM_PAD) begin
              push_o        = 1'b1;
              job_o.cnt     = 2'd1;
              job_o.bval    = 1'b1;
              job_o.data[0] = acc_q[11:4];
              phase_d       = PH_PAD1;
            end else if (sym_kind == SYM_DATA) begin
              acc_d   = {acc_q[11:0], sext};
              phase_d = PH_G3;
            end
          end
          PH_G3: begin
            if (sym_kind == SYM_PAD) begin
              push_o        = 1'b1;
              job_o.cnt     = 2'd2;
              job_o.bval    = 1'b1;
              job_o.data[0] = acc_q[17:10];
              job_o.data[1] = acc_q[9:2];
              phase_d       = PH_DONE;
            end else if (sym_kind == SYM_DATA) begin
              push_o        = 1'b1;
              job_o.cnt     = 2'd3;
              job_o.bval    = 1'b1;
              job_o.data[0] = acc_q[17:10];
              job_o.data[1] = acc_q[9:2];
              job_o.data[2] = {acc_q[1:0], sext};
              acc_d         = '0;
              phase_d       = PH_G0;
            end
          end
          PH_PAD1: begin
            if (sym_kind == SYM_PAD) begin
              phase_d = PH_DONE;
            end else if (sym_kind == SYM_DATA) begin
              err_go = 1'b1;
            end
          end
          PH_DONE: begin
            if (sym_kind != SYM_SKIP) begin
              err_go = 1'b1;
            end
          end
          default: begin
            // sticky error: every character reports, skipped ones too
            err_go = 1'b1;
          end
        endcase
        if (err_go) begin
          push_o    = 1'b1;
          job_o     = '0;
          job_o.cnt = 2'd1;
          job_o.err = 1'b1;
          phase_d   = PH_ERR;
          acc_d     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_G0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

endmodule

/* rtl/core/b64sd_queue.sv */
// job queue between front and back end, with a registered head entry
`timescale 1ns / 1ps

module b64sd_queue
  import b64sd_pkg::*;
#(
  parameter int unsigned Depth = QDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  b64sd_job_t   push_job_i,
  input  logic         pop_i,
  output b64sd_job_t   head_o,
  output b64sd_qstat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64sd_job_t      mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            head_vld_q, head_vld_d;
  b64sd_job_t      head_q;
  logic            head_take, mem_empty, bypass, mem_wr, mem_rd;

  assign mem_empty = (cnt_q == '0);
  assign head_take = !head_vld_q || pop_i;
  // with nothing stored and the head free, a push goes straight to the head
  assign bypass    = push_i && mem_empty && head_take;
  assign mem_wr    = push_i && !bypass;
  assign mem_rd    = head_take && !mem_empty;

  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    head_vld_d = head_vld_q;
    if (mem_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (mem_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (mem_wr && !mem_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!mem_wr && mem_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (head_take) begin
      head_vld_d = mem_rd || bypass;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      head_vld_q <= 1'b0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      head_vld_q <= head_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem[wr_ptr_q] <= push_job_i;
    end
    if (mem_rd) begin
      head_q <= mem[rd_ptr_q];
    end else if (bypass) begin
      head_q <= push_job_i;
    end
  end

  assign head_o       = head_q;
  assign stat_o.empty = !head_vld_q;
  assign stat_o.full  = (cnt_q == CntW'(Depth));

endmodule

/* rtl/core/b64sd_back.sv */
// back end: unrolls each job into result beats through an output register
`timescale 1ns / 1ps

module b64sd_back
  import b64sd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  b64sd_job_t   head_i,
  input  b64sd_qstat_t q_stat_i,
  output logic         pop_o,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [7:0]   m_tdata_o,
  output logic [2:0]   m_tuser_o,
  output logic         m_tlast_o
);

  b64sd_job_t job_q;
  logic       vld_q, vld_d;
  logic [1:0] idx_q, idx_d;
  logic       last_beat, load;

  assign last_beat = (idx_q == job_q.cnt - 2'd1);
  assign load      = (!vld_q || (m_tready_i && last_beat)) && !q_stat_i.empty;
  assign pop_o     = load;

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load) begin
      vld_d = 1'b1;
      idx_d = 2'd0;
    end else if (vld_q && m_tready_i) begin
      if (last_beat) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= head_i;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = job_q.data[idx_q];
  assign m_tlast_o  = last_beat;
  assign m_tuser_o  = {job_q.done && last_beat, job_q.err, job_q.bval};

endmodule

/* rtl/core/base64_stream_decoder.sv */
// top level of the streaming base64 decoder
`timescale 1ns / 1ps
//
//  channel   dir  beat contents
//  --------  ---  -------------------------------------------------------
//  s_axis    in   tdata = in_char, tuser = cmd (1 = finish and flush)
//  m_axis    out  tdata = out_byte, tuser = byte_valid/error/done_res, tlast
//  cfg       in   cfg_we_i with cfg_wdata_i = alphabet select (1 = '-' and '_')
//
//  one character is taken per cycle; the front updates phase and accumulator
//  in that cycle. each result beat leaves the output register one per cycle
//  while m_axis_tready is high, so a full group of four characters gives three beats.
//  the job queue (QDepth entries plus a head register) absorbs the burst.
//  reset puts the decoder at the start of a group with an empty queue.
//  input stalls only while the queue is full.

`include "base64_stream_decoder_defines.svh"

module base64_stream_decoder
  import b64sd_pkg::*;
#(
  parameter int unsigned QDepth = QDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tuser,   // [0] cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [0] byte_valid, [1] error, [2] done_res
  output logic       m_axis_tlast
);

  b64sd_qstat_t q_stat;
  b64sd_job_t   push_job, head_job;
  logic         push, pop;
  logic         in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  b64sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .s_tready_o  (s_axis_tready),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64sd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  b64sd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_job),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  `B64SD_ASSERT(a_err_no_byte, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])
  `B64SD_ASSERT(a_empty_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0)
  `B64SD_ASSERT(a_done_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast)
  `B64SD_ASSERT_NEXT(a_finish_queued, clk_i, rst_ni, in_fire && s_axis_tuser, !q_stat.empty)

endmodule

/* sim/base64_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the streaming base64 decoder, directed table then random messages

module base64_stream_decoder_tb;
  import b64sd_pkg::*;

  localparam logic CMD_CHAR   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam int unsigned DRAIN_CYCLES      = 16;
  localparam int unsigned ITEMS_PER_SETTING = 88;
  localparam int unsigned SETTINGS_RUN      = 4;
  localparam int unsigned DIR_ROWS          = 25;

  typedef struct packed {
    logic [7:0] obyte;
    logic       bval;
    logic       last;
    logic       err;
    logic       done;
  } b64_res_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       typed;
    b64_res_t   exp;
  } stim_row_t;

  localparam b64_res_t EXP_NONE       = '0;
  localparam b64_res_t EXP_EMPTY_DONE = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam b64_res_t EXP_ERR        = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam b64_res_t EXP_ERR_DONE   = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1};

  // standard alphabet; untyped rows are checked against the predictor
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{CMD_FINISH, 8'hFF,    1'b1, EXP_EMPTY_DONE},  // finish right after reset
    '{CMD_CHAR,   "A",      1'b0, EXP_NONE},
    '{CMD_CHAR,   "/",      1'b0, EXP_NONE},
    '{CMD_CHAR,   "+",      1'b0, EXP_NONE},
    '{CMD_CHAR,   "9",      1'b0, EXP_NONE},        // full group, three bytes
    '{CMD_CHAR,   8'h00,    1'b0, EXP_NONE},        // skipped
    '{CMD_CHAR,   "z",      1'b0, EXP_NONE},
    '{CMD_CHAR,   "Z",      1'b0, EXP_NONE},
    '{CMD_CHAR,   CH_PAD,   1'b0, EXP_NONE},        // one byte, leftover bits dropped
    '{CMD_CHAR,   "x",      1'b1, EXP_ERR},         // data after padding
    '{CMD_CHAR,   CH_PAD,   1'b1, EXP_ERR},         // sticky error
    '{CMD_FINISH, 8'h00,    1'b1, EXP_ERR_DONE},
    '{CMD_CHAR,   CH_PAD,   1'b1, EXP_ERR},         // pad at start of group
    '{CMD_FINISH, 8'h80,    1'b1, EXP_ERR_DONE},
    '{CMD_CHAR,   "a",      1'b0, EXP_NONE},
    '{CMD_CHAR,   "b",      1'b0, EXP_NONE},
    '{CMD_CHAR,   "c",      1'b0, EXP_NONE},
    '{CMD_CHAR,   CH_PAD,   1'b0, EXP_NONE},        // two bytes, padding complete
    '{CMD_FINISH, 8'h7F,    1'b1, EXP_EMPTY_DONE},
    '{CMD_CHAR,   "T",      1'b0, EXP_NONE},
    '{CMD_FINISH, 8'h00,    1'b1, EXP_ERR_DONE},    // illegal end after one sextet
    '{CMD_CHAR,   "T",      1'b0, EXP_NONE},
    '{CMD_CHAR,   "W",      1'b0, EXP_NONE},
    '{CMD_CHAR,   "F",      1'b0, EXP_NONE},
    '{CMD_FINISH, 8'hFF,    1'b0, EXP_NONE}         // flush two bytes
  };

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_char
  logic       s_axis_tuser  = 1'b0;   // [0] cmd
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [2:0] m_axis_tuser;           // [0] byte_valid, [1] error, [2] done_res
  logic       m_axis_tlast;

  // travels with the beat so the monitor sees it at the accepting edge
  logic       row_typed = 1'b0;
  b64_res_t   row_exp   = EXP_NONE;

  // decoder shadow state
  phase_e      dec_phase = PH_G0;
  logic [17:0] dec_acc   = '0;
  logic        dec_url   = 1'b0;
  logic        decode_ignored;
  b64_res_t    fresh_q[$];
  b64_res_t    pending_bytes[$];

  int unsigned err_cnt     = 0;
  int unsigned decoded_cnt = 0;
  int unsigned sink_hold   = 0;
  logic        no_idle     = 1'b0;
  logic        cur_url     = 1'b0;

  base64_stream_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void classify(input logic [7:0] c, input logic url,
                                   output sym_e kind, output logic [5:0] sx);
    kind = SYM_DATA;
    sx   = 6'd0;
    if (c >= "A" && c <= "Z") sx = 6'(c - "A");
    else if (c >= "a" && c <= "z") sx = 6'(c - "a" + 8'd26);
    else if (c >= "0" && c <= "9") sx = 6'(c - "0" + 8'd52);
    else if (c == CH_PAD) kind = SYM_PAD;
    else if (c == (url ? CH_MINUS : CH_PLUS)) sx = 6'd62;
    else if (c == (url ? CH_UNDER : CH_SLASH)) sx = 6'd63;
    else kind = SYM_SKIP;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] sx, input logic url);
    if (sx < 6'd26) return 8'h41 + 8'(sx);
    if (sx < 6'd52) return 8'h61 + 8'(sx - 6'd26);
    if (sx < 6'd62) return 8'h30 + 8'(sx - 6'd52);
    if (sx == 6'd62) return url ? CH_MINUS : CH_PLUS;
    return url ? CH_UNDER : CH_SLASH;
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic bval, input logic last,
                                   input logic err, input logic done);
    fresh_q.push_back('{b, bval, last, err, done});
  endfunction

  function automatic void flag_malformed();
    dec_phase = PH_ERR;
    dec_acc   = '0;
    add_byte(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
  endfunction

  // fills fresh_q with the beats one accepted item should produce
  function automatic void decode_char(input logic cmd, input logic [7:0] ch);
    sym_e        kind;
    logic [5:0]  sx;
    logic [23:0] grp;
    fresh_q.delete();
    decode_ignored = 1'b0;
    if (cmd == CMD_FINISH) begin
      case (dec_phase)
        PH_G0, PH_DONE: add_byte(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
        PH_G2:          add_byte(dec_acc[11:4], 1'b1, 1'b1, 1'b0, 1'b1);
        PH_G3: begin
          add_byte(dec_acc[17:10], 1'b1, 1'b0, 1'b0, 1'b0);
          add_byte(dec_acc[9:2], 1'b1, 1'b1, 1'b0, 1'b1);
        end
        default:        add_byte(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
      endcase
      dec_phase = PH_G0;
      dec_acc   = '0;
      return;
    end
    if (dec_phase == PH_ERR) begin
      flag_malformed();
      return;
    end
    classify(ch, dec_url, kind, sx);
    if (kind == SYM_SKIP) begin
      decode_ignored = 1'b1;
      return;
    end
    case (dec_phase)
      PH_G0: begin
        if (kind == SYM_PAD) flag_malformed();
        else begin
          dec_acc   = {12'h000, sx};
          dec_phase = PH_G1;
        end
      end
      PH_G1: begin
        if (kind == SYM_PAD) flag_malformed();
        else begin
          dec_acc   = {dec_acc[11:0], sx};
          dec_phase = PH_G2;
        end
      end
      PH_G2: begin
        if (kind == SYM_PAD) begin
          add_byte(dec_acc[11:4], 1'b1, 1'b1, 1'b0, 1'b0);
          dec_phase = PH_PAD1;
        end else begin
          dec_acc   = {dec_acc[11:0], sx};
          dec_phase = PH_G3;
        end
      end
      PH_G3: begin
        if (kind == SYM_PAD) begin
          add_byte(dec_acc[17:10], 1'b1, 1'b0, 1'b0, 1'b0);
          add_byte(dec_acc[9:2], 1'b1, 1'b1, 1'b0, 1'b0);
          dec_phase = PH_DONE;
        end else begin
          grp = {dec_acc, sx};
          add_byte(grp[23:16], 1'b1, 1'b0, 1'b0, 1'b0);
          add_byte(grp[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
          add_byte(grp[7:0], 1'b1, 1'b1, 1'b0, 1'b0);
          dec_acc   = '0;
          dec_phase = PH_G0;
        end
      end
      PH_PAD1: begin
        if (kind == SYM_PAD) dec_phase = PH_DONE;
        else flag_malformed();
      end
      default: flag_malformed();
    endcase
  endfunction

  task automatic report_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    err_cnt++;
  endtask

  // input and output beats are handled in one place so their order within a step is fixed
  always @(posedge clk_i) begin : mon
    b64_res_t got;
    b64_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) dec_url = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tuser, s_axis_tdata);
        if (!decode_ignored) decoded_cnt++;
        if (row_typed) pending_bytes.push_back(row_exp);
        else foreach (fresh_q[i]) pending_bytes.push_back(fresh_q[i]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1], m_axis_tuser[2]};
        if (pending_bytes.size() == 0) begin
          $display("%0t: result beat with nothing pending, actual %h", $time, got);
          err_cnt++;
        end else begin
          want = pending_bytes.pop_front();
          if (got.obyte !== want.obyte) report_field("out_byte", want.obyte, got.obyte);
          if (got.bval !== want.bval) report_field("byte_valid", 8'(want.bval), 8'(got.bval));
          if (got.last !== want.last) report_field("last", 8'(want.last), 8'(got.last));
          if (got.err !== want.err) report_field("error", 8'(want.err), 8'(got.err));
          if (got.done !== want.done) report_field("done_res", 8'(want.done), 8'(got.done));
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output back-pressure
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
    end else if (no_idle || !m_axis_tready) begin
      m_axis_tready <= 1'b1;
      sink_hold = no_idle ? 0 : $urandom_range(0, 12);
    end else begin
      sink_hold = pick_gap();
      m_axis_tready <= (sink_hold == 0);
    end
  end

  // entered and left at a rising edge; returns at the edge that takes the beat
  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic typed,
                           input b64_res_t exp_res);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= cmd;
    row_typed     <= typed;
    row_exp       <= exp_res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_item(CMD_CHAR, ch, 1'b0, EXP_NONE);
  endtask

  task automatic send_finish();
    send_item(CMD_FINISH, 8'($urandom_range(0, 255)), 1'b0, EXP_NONE);
  endtask

  function automatic logic [7:0] pick_skip();
    sym_e       kind;
    logic [5:0] sx;
    logic [7:0] c;
    // the other alphabet's two symbols are the interesting skips
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 0) return cur_url ? CH_PLUS : CH_MINUS;
      return cur_url ? CH_SLASH : CH_UNDER;
    end
    do begin
      c = 8'($urandom_range(0, 255));
      classify(c, cur_url, kind, sx);
    end while (kind != SYM_SKIP);
    return c;
  endfunction

  task automatic send_data();
    if ($urandom_range(0, 9) == 0) send_char(pick_skip());
    send_char(char_of(6'($urandom_range(0, 63)), cur_url));
  endtask

  task automatic send_message();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // well-formed message
      repeat ($urandom_range(0, 3) * 4) send_data();
      case ($urandom_range(0, 4))
        1: begin
          repeat (2) send_data();
          repeat (2) send_char(CH_PAD);
        end
        2: begin
          repeat (3) send_data();
          send_char(CH_PAD);
        end
        3: repeat (2) send_data();
        4: repeat (3) send_data();
        default: ;
      endcase
      send_finish();
    end else if (kind == 6) begin
      // raw noise, finish included now and then
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 9) == 0) send_finish();
        else send_char(8'($urandom_range(0, 255)));
      end
      send_finish();
    end else if (kind == 7) begin
      // pad at a random spot, then whatever follows
      n = $urandom_range(0, 5);
      repeat (n) send_data();
      send_char(CH_PAD);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1) == 0) send_char(CH_PAD);
        else send_data();
      end
      send_finish();
    end else if (kind == 8) begin
      send_data();
      send_finish();
    end else begin
      // unterminated run, runs into the next message
      repeat ($urandom_range(1, 6)) send_data();
    end
  endtask

  task automatic write_url(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_url = v;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned target;
    int unsigned setting;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_url(1'b0);
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_tab[i].cmd, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].exp);
    drain();

    for (setting = 0; setting < SETTINGS_RUN; setting++) begin
      write_url(~setting[0]);
      no_idle = (setting == 2);
      target = decoded_cnt + ITEMS_PER_SETTING;
      while (decoded_cnt < target) send_message();
      drain();
    end
    no_idle = 1'b0;

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* base64_stream_decoder.f */
+incdir+rtl/core
rtl/core/b64sd_pkg.sv
rtl/core/b64sd_front.sv
rtl/core/b64sd_queue.sv
rtl/core/b64sd_back.sv
rtl/core/base64_stream_decoder.sv
sim/base64_stream_decoder_tb.sv
